>>> sv/htc_pkg.sv
// Shared types and constants for the hot-end thermal controller.
// Used by every module of the block; no dependencies of its own.
package htc_pkg;

  localparam int unsigned ReadingW = 10;
  localparam int unsigned ColdW    = 13;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned BandW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FAN_ON       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FAN_OVERHEAT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FAN_HYST     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FAN_LOW      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FAN_HIGH     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_READY_BAND   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MOTION_BAND  = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [ColdW-1:0] FAN_ON_RESET       = 13'd500;
  localparam logic [ColdW-1:0] FAN_OVERHEAT_RESET = 13'd600;
  localparam logic [BandW-1:0] FAN_HYST_RESET     = 8'd20;
  localparam logic [DutyW-1:0] FAN_LOW_RESET      = 10'd200;
  localparam logic [DutyW-1:0] FAN_HIGH_RESET     = 10'd800;
  localparam logic [BandW-1:0] READY_BAND_RESET   = 8'd10;
  localparam logic [BandW-1:0] MOTION_BAND_RESET  = 8'd30;

  localparam logic [DutyW-1:0] DUTY_MAX = 10'd1023;

  typedef struct packed {
    logic [ColdW-1:0] fan_on_threshold;
    logic [ColdW-1:0] fan_overheat_threshold;
    logic [BandW-1:0] fan_hysteresis;
    logic [DutyW-1:0] fan_low_duty;
    logic [DutyW-1:0] fan_high_duty;
    logic [BandW-1:0] ready_band;
    logic [BandW-1:0] motion_band;
  } cfg_t;

  typedef struct packed {
    logic                heater_enable;
    logic [ReadingW-1:0] target_temperature;
    logic [ColdW-1:0]    coldend_sample;
    logic [ReadingW-1:0] hotend_reading;
  } sample_t;

  typedef struct packed {
    logic [ColdW-1:0] coldend_filtered_out;
    logic             motion_ok;
    logic             temp_ready;
    logic [DutyW-1:0] fan_duty_out;
    logic [DutyW-1:0] heat_duty_out;
  } result_t;

endpackage

>>> sv/htc_cfg.sv
// Configuration register file of the hot-end thermal controller.
// Depends on htc_pkg for register indexes, reset values and cfg_t.
module htc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [htc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [htc_pkg::CfgDataW-1:0]   cfg_wdata,
  output htc_pkg::cfg_t                  cfg
);
  import htc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fan_on_threshold       <= FAN_ON_RESET;
      cfg.fan_overheat_threshold <= FAN_OVERHEAT_RESET;
      cfg.fan_hysteresis         <= FAN_HYST_RESET;
      cfg.fan_low_duty           <= FAN_LOW_RESET;
      cfg.fan_high_duty          <= FAN_HIGH_RESET;
      cfg.ready_band             <= READY_BAND_RESET;
      cfg.motion_band            <= MOTION_BAND_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FAN_ON:       cfg.fan_on_threshold       <= cfg_wdata[ColdW-1:0];
        REG_FAN_OVERHEAT: cfg.fan_overheat_threshold <= cfg_wdata[ColdW-1:0];
        REG_FAN_HYST:     cfg.fan_hysteresis         <= cfg_wdata[BandW-1:0];
        REG_FAN_LOW:      cfg.fan_low_duty           <= cfg_wdata[DutyW-1:0];
        REG_FAN_HIGH:     cfg.fan_high_duty          <= cfg_wdata[DutyW-1:0];
        REG_READY_BAND:   cfg.ready_band             <= cfg_wdata[BandW-1:0];
        REG_MOTION_BAND:  cfg.motion_band            <= cfg_wdata[BandW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/htc_core.sv
// Controller state and the per-sample update: heater PD loop, cold-end
// slew filter, fan hysteresis and motion permission. Depends on htc_pkg.
module htc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  htc_pkg::sample_t sample,
  input  htc_pkg::cfg_t    cfg,
  output htc_pkg::result_t result
);
  import htc_pkg::*;

  logic [ReadingW-1:0] previous_reading;
  logic [ColdW-1:0]    coldend_filtered;
  logic [DutyW-1:0]    heat_duty;
  logic [DutyW-1:0]    fan_duty;
  logic                motion_flag;

  logic [ColdW-1:0]    coldend_filtered_next;
  logic [DutyW-1:0]    heat_duty_next;
  logic [DutyW-1:0]    fan_duty_next;
  logic                motion_flag_next;

  logic signed [10:0]  err;
  logic signed [10:0]  err_adj;
  logic signed [10:0]  err_quarter;
  logic signed [10:0]  deriv;
  logic        [10:0]  err_mag;
  logic signed [14:0]  duty_sum;
  logic                at_temp;
  logic                motion_clear;
  logic                fan_below_off;

  always_comb begin
    // Cold-end filter moves one count toward the sample.
    if (sample.coldend_sample > coldend_filtered) begin
      coldend_filtered_next = coldend_filtered + 1'b1;
    end else if (sample.coldend_sample < coldend_filtered) begin
      coldend_filtered_next = coldend_filtered - 1'b1;
    end else begin
      coldend_filtered_next = coldend_filtered;
    end

    // A hysteresis larger than the on threshold means the off level is below zero.
    fan_below_off = ({5'b0, cfg.fan_hysteresis} > cfg.fan_on_threshold) ||
                    (coldend_filtered_next <
                     (cfg.fan_on_threshold - {5'b0, cfg.fan_hysteresis}));
    if (coldend_filtered_next > cfg.fan_overheat_threshold) begin
      fan_duty_next = cfg.fan_high_duty;
    end else if (coldend_filtered_next > cfg.fan_on_threshold) begin
      fan_duty_next = cfg.fan_low_duty;
    end else if (fan_below_off) begin
      fan_duty_next = '0;
    end else begin
      fan_duty_next = fan_duty;
    end

    err     = $signed({1'b0, sample.target_temperature}) -
              $signed({1'b0, sample.hotend_reading});
    deriv   = $signed({1'b0, previous_reading}) - $signed({1'b0, sample.hotend_reading});
    err_mag = err[10] ? 11'(-err) : 11'(err);

    at_temp = (err_mag < {3'b0, cfg.ready_band}) && (sample.target_temperature != '0);
    motion_clear = (sample.target_temperature == '0) ||
                   ({2'b0, cfg.motion_band} > sample.target_temperature) ||
                   (sample.hotend_reading <
                    (sample.target_temperature - {2'b0, cfg.motion_band}));
    motion_flag_next = motion_clear ? 1'b0 : (at_temp | motion_flag);

    // Division by four truncates toward zero, so negative errors are biased first.
    err_adj     = err + (err[10] ? 11'sd3 : 11'sd0);
    err_quarter = err_adj >>> 2;
    duty_sum = $signed({5'b0, heat_duty}) +
               $signed({{4{err_quarter[10]}}, err_quarter}) +
               $signed({deriv[10], deriv, 3'b000});
    if (!sample.heater_enable || duty_sum[14]) begin
      heat_duty_next = '0;
    end else if (duty_sum[13:10] != '0) begin
      heat_duty_next = DUTY_MAX;
    end else begin
      heat_duty_next = duty_sum[9:0];
    end

    result.heat_duty_out        = heat_duty_next;
    result.fan_duty_out         = fan_duty_next;
    result.temp_ready           = at_temp;
    result.motion_ok            = motion_flag_next;
    result.coldend_filtered_out = coldend_filtered_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_reading <= '0;
      coldend_filtered <= '0;
      heat_duty        <= '0;
      fan_duty         <= '0;
      motion_flag      <= 1'b0;
    end else if (step) begin
      previous_reading <= sample.hotend_reading;
      coldend_filtered <= coldend_filtered_next;
      heat_duty        <= heat_duty_next;
      fan_duty         <= fan_duty_next;
      motion_flag      <= motion_flag_next;
    end
  end

endmodule

>>> sv/hotend_thermal_controller_unit.sv
// Hot-end thermal controller: one result per temperature sample, one sample
// per clock when the output side keeps up. A sample is registered on input
// and, when the output register is free or being read, updated through
// htc_core into the output register, where its result is valid. While a
// result waits, the input register still takes one more sample; the input
// stalls only when both registers are full. Registers are written through the
// plain write port and apply to the next sample update.
// Depends on htc_pkg, htc_cfg and htc_core.
module hotend_thermal_controller_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [9:0] hotend_reading, [22:10] coldend_sample,
  // [32:23] target_temperature, [33] heater_enable, [39:34] zero
  input  logic [htc_pkg::InDataW-1:0]     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [9:0] heat_duty_out, [19:10] fan_duty_out, [20] temp_ready,
  // [21] motion_ok, [34:22] coldend_filtered_out, [39:35] zero
  output logic [htc_pkg::OutDataW-1:0]    m_tdata,
  input  logic                            cfg_wen,
  input  logic [htc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [htc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import htc_pkg::*;

  cfg_t    cfg;
  sample_t in_item;
  logic    in_valid;
  result_t step_result;
  result_t out_item;
  logic    step;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  htc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  htc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (in_item),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= sample_t'(s_tdata[$bits(sample_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= step_result;
    end
  end

  assign m_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_item};

endmodule

>>> tb/htc_result_checker.sv
// Result checker for the hot-end thermal controller: watches the sample,
// result and register write channels, predicts every result and compares.
// Depends on htc_pkg for the field layout and register indexes.
`timescale 1ns / 1ps

module htc_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  // [9:0] hotend_reading, [22:10] coldend_sample,
  // [32:23] target_temperature, [33] heater_enable, [39:34] zero
  input  logic [htc_pkg::InDataW-1:0]  s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // [9:0] heat_duty_out, [19:10] fan_duty_out, [20] temp_ready,
  // [21] motion_ok, [34:22] coldend_filtered_out, [39:35] zero
  input  logic [htc_pkg::OutDataW-1:0] m_tdata,
  input  logic                         cfg_wen,
  input  logic [htc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [htc_pkg::CfgDataW-1:0] cfg_wdata,
  output int                           mismatch_count,
  output int                           outstanding
);
  import htc_pkg::*;

  typedef struct packed {
    logic [ReadingW-1:0] prev_reading;
    logic [ColdW-1:0]    cold_filt;
    logic [DutyW-1:0]    heater;
    logic [DutyW-1:0]    fan;
    logic                motion;
  } loop_state_t;

  loop_state_t st;
  cfg_t        cfg;
  result_t     expected_results[$];
  result_t     want;
  result_t     got;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  // Advances the controller state by one sample tick and returns the result.
  function automatic result_t thermal_update(input sample_t smp);
    int      deriv;
    int      err;
    int      mag;
    int      duty;
    logic    at_temp;
    result_t r;
    deriv = int'(st.prev_reading) - int'(smp.hotend_reading);
    st.prev_reading = smp.hotend_reading;

    if (smp.coldend_sample > st.cold_filt) st.cold_filt = st.cold_filt + 1'b1;
    else if (smp.coldend_sample < st.cold_filt) st.cold_filt = st.cold_filt - 1'b1;

    // A hysteresis above the on threshold wraps below zero, so the fan
    // then turns off whenever it is above neither the on nor the overheat threshold.
    if (st.cold_filt > cfg.fan_overheat_threshold) begin
      st.fan = cfg.fan_high_duty;
    end else if (st.cold_filt > cfg.fan_on_threshold) begin
      st.fan = cfg.fan_low_duty;
    end else if (cfg.fan_hysteresis > cfg.fan_on_threshold ||
                 int'(st.cold_filt) <
                 int'(cfg.fan_on_threshold) - int'(cfg.fan_hysteresis)) begin
      st.fan = '0;
    end

    err = int'(smp.target_temperature) - int'(smp.hotend_reading);
    mag = (err < 0) ? -err : err;
    at_temp = (mag < int'(cfg.ready_band)) && (smp.target_temperature != '0);
    if (at_temp) st.motion = 1'b1;
    // Clearing wins; a band above the target also clears.
    if (smp.target_temperature == '0 || cfg.motion_band > smp.target_temperature ||
        int'(smp.hotend_reading) <
        int'(smp.target_temperature) - int'(cfg.motion_band)) begin
      st.motion = 1'b0;
    end

    if (smp.heater_enable) begin
      duty = int'(st.heater) + err / 4 + deriv * 8;
      if (duty > int'(DUTY_MAX)) duty = int'(DUTY_MAX);
      if (duty < 0) duty = 0;
      st.heater = DutyW'(duty);
    end else begin
      st.heater = '0;
    end

    r.heat_duty_out        = st.heater;
    r.fan_duty_out         = st.fan;
    r.temp_ready           = at_temp;
    r.motion_ok            = st.motion;
    r.coldend_filtered_out = st.cold_filt;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      st = '0;
      cfg.fan_on_threshold       = FAN_ON_RESET;
      cfg.fan_overheat_threshold = FAN_OVERHEAT_RESET;
      cfg.fan_hysteresis         = FAN_HYST_RESET;
      cfg.fan_low_duty           = FAN_LOW_RESET;
      cfg.fan_high_duty          = FAN_HIGH_RESET;
      cfg.ready_band             = READY_BAND_RESET;
      cfg.motion_band            = MOTION_BAND_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_FAN_ON:       cfg.fan_on_threshold       = cfg_wdata[ColdW-1:0];
          REG_FAN_OVERHEAT: cfg.fan_overheat_threshold = cfg_wdata[ColdW-1:0];
          REG_FAN_HYST:     cfg.fan_hysteresis         = cfg_wdata[BandW-1:0];
          REG_FAN_LOW:      cfg.fan_low_duty           = cfg_wdata[DutyW-1:0];
          REG_FAN_HIGH:     cfg.fan_high_duty          = cfg_wdata[DutyW-1:0];
          REG_READY_BAND:   cfg.ready_band             = cfg_wdata[BandW-1:0];
          REG_MOTION_BAND:  cfg.motion_band            = cfg_wdata[BandW-1:0];
          default: ;
        endcase
      end

      // Retire the result transfer first, so a sample accepted at the same
      // edge can never stand in for a missing expectation.
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result pending");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("heat_duty_out", want.heat_duty_out, got.heat_duty_out);
          check_field("fan_duty_out", want.fan_duty_out, got.fan_duty_out);
          check_field("temp_ready", want.temp_ready, got.temp_ready);
          check_field("motion_ok", want.motion_ok, got.motion_ok);
          check_field("coldend_filtered_out", want.coldend_filtered_out,
                      got.coldend_filtered_out);
          check_field("tdata padding", 0, m_tdata[OutDataW-1:$bits(result_t)]);
        end
      end

      if (s_tvalid && s_tready) begin
        expected_results.push_back(thermal_update(sample_t'(s_tdata[$bits(sample_t)-1:0])));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> tb/tb_hotend_thermal_controller_unit.sv
// Top of the hot-end thermal controller testbench: clock, reset, sample
// stimulus, result back-pressure, register phases and the verdict.
// Depends on htc_pkg, hotend_thermal_controller_unit and htc_result_checker.
`timescale 1ns / 1ps

module tb_hotend_thermal_controller_unit;
  import htc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT     = 600;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_wen = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int mismatch_count;
  int outstanding;
  int quiet_cycles;
  int in_count;
  int rx_hold;
  bit long_hold_done;
  bit idle_enable = 1'b1;

  int cur_target;
  int cold_goal;
  int last_reading;

  hotend_thermal_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  htc_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off while samples
  // keep coming so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready       <= 1'b0;
      rx_hold        <= 0;
      long_hold_done <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (!long_hold_done && in_count >= HOLD_AT) begin
      rx_hold        <= LONG_HOLD;
      long_hold_done <= 1'b1;
      m_tready       <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      rx_hold  <= $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
      in_count     <= 0;
    end else begin
      if (s_tvalid && s_tready) in_count <= in_count + 1;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[hotend_thermal_controller_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int clamp_to(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  task automatic push_sample(input int reading, input int sample, input int target,
                             input bit en);
    sample_t smp;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    smp.hotend_reading     = ReadingW'(reading);
    smp.coldend_sample     = ColdW'(sample);
    smp.target_temperature = ReadingW'(target);
    smp.heater_enable      = en;
    s_tdata  <= InDataW'(smp);
    s_tvalid <= 1'b1;
    last_reading = reading;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering samples and waits until every result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Narrow registers get random bits above their width, which must be dropped.
  task automatic set_config(input logic [ColdW-1:0] on_thr, input logic [ColdW-1:0] hot_thr,
                            input logic [BandW-1:0] hyst, input logic [DutyW-1:0] lo_duty,
                            input logic [DutyW-1:0] hi_duty, input logic [BandW-1:0] rdy,
                            input logic [BandW-1:0] mot);
    wait_drained();
    write_reg(REG_FAN_ON, on_thr);
    write_reg(REG_FAN_OVERHEAT, hot_thr);
    write_reg(REG_FAN_HYST, {5'($urandom), hyst});
    write_reg(REG_FAN_LOW, {3'($urandom), lo_duty});
    write_reg(REG_FAN_HIGH, {3'($urandom), hi_duty});
    write_reg(REG_READY_BAND, {5'($urandom), rdy});
    write_reg(REG_MOTION_BAND, {5'($urandom), mot});
    write_reg(REG_UNUSED, 13'($urandom));
    cfg_wen <= 1'b0;
  endtask

  // Mostly slow-moving targets and cold-end goals with readings near the
  // target, so the bands, motion flag and fan thresholds all get crossed.
  task automatic send_random(input int count, input int cold_span);
    int reading;
    int sample;
    int sel;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) cold_goal = $urandom_range(0, cold_span);
      if ($urandom_range(0, 19) == 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) cur_target = 0;
        else if (sel == 1) cur_target = $urandom_range(1, 40);
        else cur_target = $urandom_range(1, 1023);
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) sample = $urandom_range(0, 8191);
      else if (sel == 1) sample = cold_goal + int'($urandom_range(0, 6)) - 3;
      else sample = cold_goal;
      sel = $urandom_range(0, 3);
      if (sel < 2) reading = cur_target + int'($urandom_range(0, 80)) - 40;
      else if (sel == 2) reading = last_reading + int'($urandom_range(0, 16)) - 8;
      else reading = $urandom_range(0, 1023);
      push_sample(clamp_to(reading, 1023), clamp_to(sample, 8191), cur_target,
                  $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    cur_target   = 500;
    cold_goal    = 0;
    last_reading = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples under the reset register values.
    push_sample(0, 0, 0, 1'b0);
    push_sample(1023, 8191, 1023, 1'b1);  // on target after a large rise in reading
    push_sample(0, 8191, 1023, 1'b1);     // duty saturates high
    push_sample(500, 0, 500, 1'b1);       // exactly on target
    push_sample(509, 0, 500, 1'b1);       // just inside the ready band
    push_sample(510, 0, 500, 1'b1);       // on the band edge: not ready
    push_sample(470, 0, 500, 1'b1);       // reading at target minus band keeps motion
    push_sample(469, 0, 500, 1'b1);       // one below clears motion
    push_sample(495, 0, 500, 1'b0);       // ready while the heater is disabled
    push_sample(0, 0, 0, 1'b1);           // zero error but no target
    push_sample(15, 0, 20, 1'b1);         // ready, but band above target clears motion
    push_sample(30, 0, 30, 1'b1);         // band equal to target
    push_sample(1023, 0, 0, 1'b1);        // duty saturates low
    push_sample(512, 4095, 700, 1'b1);
    push_sample(1023, 8191, 1, 1'b0);
    push_sample(0, 8191, 1023, 1'b0);
    send_random(150, 700);

    set_config(13'd30, 13'd60, 8'd10, 10'd300, 10'd1023, 8'd20, 8'd40);
    send_random(350, 100);
    set_config(13'd0, 13'd0, 8'd0, 10'd0, 10'd0, 8'd0, 8'd0);
    send_random(150, 20);
    // Hysteresis above the on threshold.
    set_config(13'd15, 13'd45, 8'd255, 10'd1023, 10'd512, 8'd255, 8'd255);
    send_random(300, 80);
    set_config(13'd8191, 13'd8191, 8'd255, 10'd1023, 10'd1023, 8'd255, 8'd255);
    send_random(150, 200);
    // Overheat threshold below the on threshold.
    set_config(13'd40, 13'd25, 8'd30, 10'd77, 10'd900, 8'd5, 8'd10);
    send_random(350, 90);
    set_config(13'd35, 13'd70, 8'd20, 10'd200, 10'd800, 8'd10, 8'd30);
    idle_enable <= 1'b0;
    send_random(400, 110);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[hotend_thermal_controller_unit] OK");
    end else begin
      $display("[hotend_thermal_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/htc_pkg.sv
sv/htc_cfg.sv
sv/htc_core.sv
sv/hotend_thermal_controller_unit.sv
tb/htc_result_checker.sv
tb/tb_hotend_thermal_controller_unit.sv
